// ===== rtl/core/tccc_pkg.sv =====
// Shared types and constants for the text console cursor controller.
// Holds the result layout, command kinds and control character codes.
// No dependencies.
package tccc_pkg;

    // Column advance for a tab: next multiple of this stop
    localparam int unsigned TAB_STOP = 8;

    localparam int unsigned CHAR_W  = 21;
    localparam int unsigned COORD_W = 8;

    // Control character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL = 21'd0;
    localparam logic [CHAR_W-1:0] CHAR_BS  = 21'd8;
    localparam logic [CHAR_W-1:0] CHAR_TAB = 21'd9;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 21'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR  = 21'd13;
    localparam logic [CHAR_W-1:0] GLYPH_SPACE = 21'h20;

    // Register indexes on the config port
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    localparam logic [COORD_W-1:0] COLS_RESET = 8'd80;
    localparam logic [COORD_W-1:0] ROWS_RESET = 8'd25;

    // Grid command kinds
    typedef enum logic [1:0] {
        KIND_SCROLL = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_CURSOR = 2'd3
    } kind_t;

    // One grid command
    typedef struct packed {
        kind_t               kind;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [CHAR_W-1:0]   glyph;
        logic                last;
    } result_t;

endpackage

// ===== rtl/core/text_console_cursor_controller.sv =====
// The first grid command of an item is offered once the input register has passed the
// item to the result buffer. Output: one command per cycle while m_tready is high, so an
// item yields 1 to 3 commands (clear: 1; print: 1 + scroll + cell write).
// Reset (rst_n low, async): cursor and mark at (0,0), cols 80, rows 25,
// input and output stages empty.
// Depends on tccc_pkg.
module text_console_cursor_controller
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] char_code, [23:21] zero
    input  logic        s_tuser,   // [0] mode
    // Command stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] col, [15:8] row, [36:16] glyph, [39:37] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    localparam int unsigned CW = tccc_pkg::COORD_W;

    // Config registers
    logic [CW-1:0] cols_reg;
    logic [CW-1:0] rows_reg;

    // Cursor and line-start mark
    logic [CW-1:0] cursor_col_reg, cursor_row_reg, mark_col_reg, mark_row_reg;
    logic [CW-1:0] cursor_col_next, cursor_row_next, mark_col_next, mark_row_next;

    // Input register
    logic                         in_valid_reg;
    logic                         in_mode_reg;
    logic [tccc_pkg::CHAR_W-1:0]  in_char_reg;

    // Result buffer, head at entry 0
    tccc_pkg::result_t res_reg [3];
    tccc_pkg::result_t slot    [3];
    logic [1:0]        rem_reg;
    logic [1:0]        slot_n;

    logic take;
    logic pop;

    // Scroll check and intermediate values
    logic [2*CW-1:0] row_prod;
    logic [2*CW-1:0] lim;
    logic [2*CW:0]   lin_p1;
    logic            do_scroll;
    logic [CW-1:0]   sc_row, sc_mrow, sc_mcol, row_inc, row_dec;
    logic [CW:0]     tab_t, tab_w;
    logic            mark_behind;
    logic            has_write;
    logic [tccc_pkg::CHAR_W-1:0] wr_glyph;

    tccc_pkg::result_t scroll_r, write_r, cursor_r, clear_r;

    // Tab target column for each start column
    logic [CW:0] tab_next [256];

    genvar g;
    generate
        for (g = 0; g < 256; g++)
        begin : g_tab
            assign tab_next[g] = 9'(g + tccc_pkg::TAB_STOP - (g % tccc_pkg::TAB_STOP));
        end
    endgenerate

    // Handshakes
    assign pop      = m_tvalid && m_tready;
    assign take     = in_valid_reg && ((rem_reg == 2'd0) || ((rem_reg == 2'd1) && m_tready));
    assign s_tready = !in_valid_reg || take;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= tccc_pkg::COLS_RESET;
            rows_reg <= tccc_pkg::ROWS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == tccc_pkg::CFG_COLS)
                cols_reg <= cfg_data;
            else
                rows_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser;
            in_char_reg <= s_tdata[tccc_pkg::CHAR_W-1:0];
        end
    end

    // Scroll when the cursor is on or past the last cell
    assign row_prod  = {8'd0, cursor_row_reg} * {8'd0, cols_reg};
    assign lim       = {8'd0, cols_reg} * {8'd0, rows_reg};
    assign lin_p1    = {1'b0, row_prod} + {9'd0, cursor_col_reg} + 17'd1;
    assign do_scroll = lin_p1 >= {1'b0, lim};

    // Position after the optional scroll
    always_comb
    begin
        sc_row  = cursor_row_reg;
        sc_mrow = mark_row_reg;
        sc_mcol = mark_col_reg;
        if (do_scroll)
        begin
            if (cursor_row_reg != '0)
                sc_row = cursor_row_reg - 8'd1;
            if (mark_row_reg != '0)
                sc_mrow = mark_row_reg - 8'd1;
            else
            begin
                sc_mrow = '0;
                sc_mcol = '0;
            end
        end
    end

    assign row_inc     = (sc_row != 8'hFF) ? sc_row + 8'd1 : sc_row;
    assign row_dec     = (sc_row != '0) ? sc_row - 8'd1 : sc_row;
    assign mark_behind = (sc_mrow < sc_row) ||
                         ((sc_mrow == sc_row) && (sc_mcol < cursor_col_reg));
    assign tab_t       = tab_next[cursor_col_reg];
    assign tab_w       = tab_t - {1'b0, cols_reg};

    // Character handling
    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = sc_row;
        mark_col_next   = sc_mcol;
        mark_row_next   = sc_mrow;
        has_write       = 1'b1;
        wr_glyph        = tccc_pkg::GLYPH_SPACE;
        unique case (in_char_reg)
            tccc_pkg::CHAR_NUL:
            begin
                has_write = 1'b0;
            end
            tccc_pkg::CHAR_TAB:
            begin
                if (tab_t >= {1'b0, cols_reg})
                begin
                    cursor_col_next = (tab_w >= {1'b0, cols_reg}) ? '0 : tab_w[CW-1:0];
                    cursor_row_next = row_inc;
                end
                else
                    cursor_col_next = tab_t[CW-1:0];
            end
            tccc_pkg::CHAR_LF:
            begin
                cursor_col_next = '0;
                cursor_row_next = row_inc;
                mark_col_next   = '0;
                mark_row_next   = row_inc;
            end
            tccc_pkg::CHAR_CR:
            begin
                has_write       = 1'b0;
                cursor_col_next = '0;
                mark_col_next   = '0;
                mark_row_next   = sc_row;
            end
            tccc_pkg::CHAR_BS:
            begin
                if (mark_behind)
                begin
                    if (cursor_col_reg == '0)
                    begin
                        cursor_col_next = (cols_reg != '0) ? cols_reg - 8'd1 : '0;
                        cursor_row_next = row_dec;
                    end
                    else
                        cursor_col_next = cursor_col_reg - 8'd1;
                end
            end
            default:
            begin
                wr_glyph = in_char_reg;
                if (({1'b0, cursor_col_reg} + 9'd1) >= {1'b0, cols_reg})
                begin
                    cursor_col_next = '0;
                    cursor_row_next = row_inc;
                end
                else
                    cursor_col_next = cursor_col_reg + 8'd1;
            end
        endcase
    end

    // Command assembly
    always_comb
    begin
        scroll_r = '{kind: tccc_pkg::KIND_SCROLL, col: '0, row: '0, glyph: '0, last: 1'b0};
        clear_r  = '{kind: tccc_pkg::KIND_CLEAR,  col: '0, row: '0, glyph: '0, last: 1'b1};
        write_r  = '{kind: tccc_pkg::KIND_WRITE, col: cursor_col_reg, row: sc_row,
                     glyph: wr_glyph, last: 1'b0};
        cursor_r = '{kind: tccc_pkg::KIND_CURSOR, col: cursor_col_next, row: cursor_row_next,
                     glyph: tccc_pkg::GLYPH_SPACE, last: 1'b1};
        slot[2]  = cursor_r;
        if (in_mode_reg)
        begin
            slot[0] = clear_r;
            slot[1] = cursor_r;
            slot_n  = 2'd1;
        end
        else
        begin
            if (do_scroll)
                slot[0] = scroll_r;
            else if (has_write)
                slot[0] = write_r;
            else
                slot[0] = cursor_r;
            if (do_scroll && has_write)
                slot[1] = write_r;
            else
                slot[1] = cursor_r;
            slot_n = 2'd1 + {1'b0, do_scroll} + {1'b0, has_write};
        end
    end

    // Cursor and mark update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            mark_col_reg   <= '0;
            mark_row_reg   <= '0;
        end
        else if (take)
        begin
            if (in_mode_reg)
            begin
                cursor_col_reg <= '0;
                cursor_row_reg <= '0;
                mark_col_reg   <= '0;
                mark_row_reg   <= '0;
            end
            else
            begin
                cursor_col_reg <= cursor_col_next;
                cursor_row_reg <= cursor_row_next;
                mark_col_reg   <= mark_col_next;
                mark_row_reg   <= mark_row_next;
            end
        end
    end

    // Result buffer: load all commands of an item, shift out one per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= 2'd0;
        else if (take)
            rem_reg <= slot_n;
        else if (pop)
            rem_reg <= rem_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg[0] <= slot[0];
            res_reg[1] <= slot[1];
            res_reg[2] <= slot[2];
        end
        else if (pop)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    // Output port
    assign m_tvalid = rem_reg != 2'd0;
    assign m_tuser  = res_reg[0].kind;
    assign m_tlast  = res_reg[0].last;
    assign m_tdata  = {3'b000, res_reg[0].glyph, res_reg[0].row, res_reg[0].col};

`ifndef SYNTHESIS
    // Last flag marks exactly the final buffered command
    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (rem_reg == 2'd1)))
        else $error("tlast does not match the end of the buffered commands");

    // Only cursor draws and clears close an item
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == ((m_tuser == tccc_pkg::KIND_CURSOR) ||
                                  (m_tuser == tccc_pkg::KIND_CLEAR))))
        else $error("tlast on a command kind that cannot end an item");

    // A scroll is always followed by at least a cursor draw
    a_scroll_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == tccc_pkg::KIND_SCROLL)) |-> (rem_reg >= 2'd2))
        else $error("scroll without a following command");

    // A clear homes cursor and mark
    a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_mode_reg) |=> ((cursor_col_reg == '0) && (cursor_row_reg == '0) &&
                                   (mark_col_reg == '0) && (mark_row_reg == '0)))
        else $error("clear did not home cursor and mark");

    // No new item loads while more than one command is still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg > 2'd1) |-> !take)
        else $error("result buffer overrun");
`endif

endmodule

// ===== tb/text_console_cursor_controller_tb.sv =====
// Testbench for the text console cursor controller: directed table, then random
// character streams over several grid sizes, checked against a cursor predictor.
// Depends on tccc_pkg and text_console_cursor_controller.
`timescale 1ns / 1ps

module text_console_cursor_controller_tb;

    localparam int unsigned CLK_HALF       = 2;
    localparam int unsigned RESET_CYCLES   = 10;
    localparam int unsigned DRAIN_CYCLES   = 6;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned QUIET_LIMIT    = 2000;
    localparam int unsigned PHASE_ITEMS    = 34;
    localparam int unsigned NUM_PHASES     = 9;
    localparam int unsigned CLEAR_PCT      = 4;
    localparam int unsigned CODE_W         = tccc_pkg::CHAR_W;

    // Idle schemes, one per random phase in turn
    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One row of the directed table: a size change or one input transfer
    typedef struct {
        bit                 is_cfg;
        logic               clr;
        logic [CODE_W-1:0]  code;
        logic [7:0]         cols_v;
        logic [7:0]         rows_v;
        int                 n_typed;
        tccc_pkg::result_t  exp_a;
        tccc_pkg::result_t  exp_b;
    } stim_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data  = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = 24'd0;   // [20:0] char_code, [23:21] zero
    logic        s_tuser   = 1'b0;    // [0] mode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;             // [7:0] col, [15:8] row, [36:16] glyph, [39:37] zero
    logic [1:0]  m_tuser;             // [1:0] kind
    logic        m_tlast;

    // Predicted cursor state and grid size
    int unsigned grid_cols = tccc_pkg::COLS_RESET;
    int unsigned grid_rows = tccc_pkg::ROWS_RESET;
    int unsigned cur_col   = 0;
    int unsigned cur_row   = 0;
    int unsigned mark_c    = 0;
    int unsigned mark_r    = 0;

    tccc_pkg::result_t pending_cmds[$];
    stim_row_t         dir_tbl[$];
    int                err_count     = 0;
    int unsigned       snd_idle_pct  = 0;
    int unsigned       rcv_stall_pct = 0;
    int unsigned       hold_requests = 0;
    int unsigned       hold_served   = 0;

    text_console_cursor_controller dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic tccc_pkg::result_t make_cmd(tccc_pkg::kind_t k, logic [7:0] c,
                                                   logic [7:0] r, logic [CODE_W-1:0] g,
                                                   logic lst);
        tccc_pkg::result_t cmd;
        cmd.kind  = k;
        cmd.col   = c;
        cmd.row   = r;
        cmd.glyph = g;
        cmd.last  = lst;
        return cmd;
    endfunction

    // Row increment saturates at the top of the 8-bit range
    function automatic void step_row_down();
        if (cur_row < 255)
            cur_row++;
    endfunction

    // Work out the grid commands for one accepted item and move the cursor
    task automatic advance_cursor(input logic clr, input logic [CODE_W-1:0] code,
                                  input bit keep);
        tccc_pkg::result_t cmds[$];
        int unsigned       t;
        bit                mark_ahead;
        if (clr)
        begin
            cmds.push_back(make_cmd(tccc_pkg::KIND_CLEAR, 8'd0, 8'd0, '0, 1'b0));
            cur_col = 0;
            cur_row = 0;
            mark_c  = 0;
            mark_r  = 0;
        end
        else
        begin
            // Scroll first when at or past the last cell; mark saturates at home
            if (cur_row * grid_cols + cur_col + 1 >= grid_cols * grid_rows)
            begin
                cmds.push_back(make_cmd(tccc_pkg::KIND_SCROLL, 8'd0, 8'd0, '0, 1'b0));
                if (cur_row > 0)
                    cur_row--;
                if (mark_r > 0)
                    mark_r--;
                else
                    mark_c = 0;
            end
            case (code)
                tccc_pkg::CHAR_NUL:
                begin
                    // cursor draw only
                end
                tccc_pkg::CHAR_TAB:
                begin
                    cmds.push_back(make_cmd(tccc_pkg::KIND_WRITE, 8'(cur_col), 8'(cur_row),
                                            tccc_pkg::GLYPH_SPACE, 1'b0));
                    t = cur_col + tccc_pkg::TAB_STOP - (cur_col % tccc_pkg::TAB_STOP);
                    if (t >= grid_cols)
                    begin
                        t -= grid_cols;
                        if (t >= grid_cols)
                            t = 0;
                        step_row_down();
                    end
                    cur_col = t;
                end
                tccc_pkg::CHAR_LF:
                begin
                    cmds.push_back(make_cmd(tccc_pkg::KIND_WRITE, 8'(cur_col), 8'(cur_row),
                                            tccc_pkg::GLYPH_SPACE, 1'b0));
                    cur_col = 0;
                    step_row_down();
                    mark_c = cur_col;
                    mark_r = cur_row;
                end
                tccc_pkg::CHAR_CR:
                begin
                    cur_col = 0;
                    mark_c  = 0;
                    mark_r  = cur_row;
                end
                tccc_pkg::CHAR_BS:
                begin
                    cmds.push_back(make_cmd(tccc_pkg::KIND_WRITE, 8'(cur_col), 8'(cur_row),
                                            tccc_pkg::GLYPH_SPACE, 1'b0));
                    mark_ahead = (mark_r < cur_row) || (mark_r == cur_row && mark_c < cur_col);
                    if (mark_ahead)
                    begin
                        if (cur_col == 0)
                        begin
                            cur_col = (grid_cols > 0) ? grid_cols - 1 : 0;
                            if (cur_row > 0)
                                cur_row--;
                        end
                        else
                            cur_col--;
                    end
                end
                default:
                begin
                    cmds.push_back(make_cmd(tccc_pkg::KIND_WRITE, 8'(cur_col), 8'(cur_row),
                                            code, 1'b0));
                    if (cur_col + 1 >= grid_cols)
                    begin
                        cur_col = 0;
                        step_row_down();
                    end
                    else
                        cur_col++;
                end
            endcase
            cmds.push_back(make_cmd(tccc_pkg::KIND_CURSOR, 8'(cur_col), 8'(cur_row),
                                    tccc_pkg::GLYPH_SPACE, 1'b0));
        end
        cmds[cmds.size() - 1].last = 1'b1;
        if (keep)
            foreach (cmds[i])
                pending_cmds.push_back(cmds[i]);
    endtask

    // Offer one item after a random gap; returns at the edge that takes it
    task automatic push_item(input logic clr, input logic [CODE_W-1:0] code,
                             input bit predict);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= clr;
        s_tdata  <= {3'b000, code};
        do
            @(posedge clk);
        while (!s_tready);
        advance_cursor(clr, code, predict);
    endtask

    // Resize the grid once the block has gone quiet
    task automatic set_size(input logic [7:0] c, input logic [7:0] r);
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= tccc_pkg::CFG_COLS;
        cfg_data  <= c;
        @(posedge clk);
        cfg_index <= tccc_pkg::CFG_ROWS;
        cfg_data  <= r;
        @(posedge clk);
        cfg_we    <= 1'b0;
        grid_cols = c;
        grid_rows = r;
    endtask

    function automatic void tbl_size(logic [7:0] c, logic [7:0] r);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cols_v = c;
        row.rows_v = r;
        dir_tbl.push_back(row);
    endfunction

    function automatic void tbl_item(logic clr, logic [CODE_W-1:0] code);
        stim_row_t row;
        row = '{default: '0};
        row.clr  = clr;
        row.code = code;
        dir_tbl.push_back(row);
    endfunction

    function automatic void tbl_typed(logic clr, logic [CODE_W-1:0] code, int n,
                                      tccc_pkg::result_t a, tccc_pkg::result_t b);
        stim_row_t row;
        row = '{default: '0};
        row.clr     = clr;
        row.code    = code;
        row.n_typed = n;
        row.exp_a   = a;
        row.exp_b   = b;
        dir_tbl.push_back(row);
    endfunction

    // Mostly control characters and printables, some full-range code points
    function automatic logic [CODE_W-1:0] pick_code();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return tccc_pkg::CHAR_NUL;
        else if (sel < 20)
            return tccc_pkg::CHAR_BS;
        else if (sel < 32)
            return tccc_pkg::CHAR_TAB;
        else if (sel < 42)
            return tccc_pkg::CHAR_LF;
        else if (sel < 50)
            return tccc_pkg::CHAR_CR;
        else if (sel < 85)
            return CODE_W'($urandom_range(8'h7e, 8'h21));
        else if (sel < 95)
            return CODE_W'($urandom_range(21'h1FFFFF, 0));
        else
            return CODE_W'($urandom_range(31, 0));
    endfunction

    // Command side: check each transfer, then pick tready for the next edge
    initial
    begin
        int unsigned       hold_left;
        tccc_pkg::result_t want;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_cmds.size() == 0)
                begin
                    $error("command with no expectation: kind %0d col %0d row %0d glyph %0h",
                           m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[36:16]);
                    err_count++;
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    if (m_tuser != want.kind)
                    begin
                        $error("kind mismatch: expected %0d, got %0d", want.kind, m_tuser);
                        err_count++;
                    end
                    if (m_tdata[7:0] != want.col)
                    begin
                        $error("col mismatch: expected %0d, got %0d", want.col, m_tdata[7:0]);
                        err_count++;
                    end
                    if (m_tdata[15:8] != want.row)
                    begin
                        $error("row mismatch: expected %0d, got %0d", want.row, m_tdata[15:8]);
                        err_count++;
                    end
                    if (m_tdata[36:16] != want.glyph)
                    begin
                        $error("glyph mismatch: expected %0h, got %0h", want.glyph,
                               m_tdata[36:16]);
                        err_count++;
                    end
                    if (m_tlast != want.last)
                    begin
                        $error("last mismatch: expected %0b, got %0b", want.last, m_tlast);
                        err_count++;
                    end
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                hold_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Watchdog: too long without any transfer on either side
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus
    initial
    begin
        stim_row_t   row;
        logic [7:0]  ph_cols[NUM_PHASES];
        logic [7:0]  ph_rows[NUM_PHASES];
        idle_mode_t  mode;

        ph_cols = '{8'd80, 8'd8, 8'd255, 8'd12, 8'd255, 8'd8, 8'd0, 8'd17, 8'd40};
        ph_rows = '{8'd25, 8'd1, 8'd255, 8'd3, 8'd1, 8'd255, 8'd3, 8'd0, 8'd2};

        // Directed rows from reset: 80 x 25, cursor and mark at home
        tbl_typed(1'b0, 21'h41, 2,
                  make_cmd(tccc_pkg::KIND_WRITE, 8'd0, 8'd0, 21'h41, 1'b0),
                  make_cmd(tccc_pkg::KIND_CURSOR, 8'd1, 8'd0, tccc_pkg::GLYPH_SPACE, 1'b1));
        // clear ignores the code field
        tbl_typed(1'b1, 21'h1FFFFF, 1,
                  make_cmd(tccc_pkg::KIND_CLEAR, 8'd0, 8'd0, '0, 1'b1), '0);
        tbl_typed(1'b0, tccc_pkg::CHAR_NUL, 1,
                  make_cmd(tccc_pkg::KIND_CURSOR, 8'd0, 8'd0, tccc_pkg::GLYPH_SPACE, 1'b1),
                  '0);
        tbl_typed(1'b0, 21'h1FFFFF, 2,
                  make_cmd(tccc_pkg::KIND_WRITE, 8'd0, 8'd0, 21'h1FFFFF, 1'b0),
                  make_cmd(tccc_pkg::KIND_CURSOR, 8'd1, 8'd0, tccc_pkg::GLYPH_SPACE, 1'b1));
        tbl_typed(1'b0, tccc_pkg::CHAR_TAB, 2,
                  make_cmd(tccc_pkg::KIND_WRITE, 8'd1, 8'd0, tccc_pkg::GLYPH_SPACE, 1'b0),
                  make_cmd(tccc_pkg::KIND_CURSOR, 8'd8, 8'd0, tccc_pkg::GLYPH_SPACE, 1'b1));
        tbl_typed(1'b0, tccc_pkg::CHAR_BS, 2,
                  make_cmd(tccc_pkg::KIND_WRITE, 8'd8, 8'd0, tccc_pkg::GLYPH_SPACE, 1'b0),
                  make_cmd(tccc_pkg::KIND_CURSOR, 8'd7, 8'd0, tccc_pkg::GLYPH_SPACE, 1'b1));
        tbl_typed(1'b0, tccc_pkg::CHAR_CR, 1,
                  make_cmd(tccc_pkg::KIND_CURSOR, 8'd0, 8'd0, tccc_pkg::GLYPH_SPACE, 1'b1),
                  '0);
        // backspace at the mark erases but does not move
        tbl_typed(1'b0, tccc_pkg::CHAR_BS, 2,
                  make_cmd(tccc_pkg::KIND_WRITE, 8'd0, 8'd0, tccc_pkg::GLYPH_SPACE, 1'b0),
                  make_cmd(tccc_pkg::KIND_CURSOR, 8'd0, 8'd0, tccc_pkg::GLYPH_SPACE, 1'b1));
        tbl_typed(1'b0, tccc_pkg::CHAR_LF, 2,
                  make_cmd(tccc_pkg::KIND_WRITE, 8'd0, 8'd0, tccc_pkg::GLYPH_SPACE, 1'b0),
                  make_cmd(tccc_pkg::KIND_CURSOR, 8'd0, 8'd1, tccc_pkg::GLYPH_SPACE, 1'b1));
        tbl_item(1'b0, 21'h42);
        tbl_item(1'b0, tccc_pkg::CHAR_BS);
        tbl_item(1'b0, tccc_pkg::CHAR_BS);
        // eight-column grid: tab wraps, backspace from column 0 goes up a row
        tbl_size(8'd8, 8'd255);
        tbl_item(1'b0, tccc_pkg::CHAR_TAB);
        tbl_item(1'b0, tccc_pkg::CHAR_CR);
        tbl_item(1'b0, tccc_pkg::CHAR_TAB);
        tbl_item(1'b0, tccc_pkg::CHAR_BS);
        // column left beyond cols after shrinking: tab lands on column 0
        tbl_size(8'd255, 8'd255);
        tbl_item(1'b0, tccc_pkg::CHAR_TAB);
        tbl_item(1'b0, tccc_pkg::CHAR_TAB);
        tbl_item(1'b0, tccc_pkg::CHAR_TAB);
        tbl_size(8'd8, 8'd255);
        tbl_item(1'b0, tccc_pkg::CHAR_TAB);
        // out-of-range column on an ordinary print, with scroll and mark moving up
        tbl_size(8'd255, 8'd255);
        tbl_item(1'b0, tccc_pkg::CHAR_TAB);
        tbl_item(1'b0, tccc_pkg::CHAR_TAB);
        tbl_item(1'b0, tccc_pkg::CHAR_TAB);
        tbl_size(8'd8, 8'd1);
        tbl_item(1'b0, 21'h46);
        tbl_item(1'b0, 21'h47);
        tbl_item(1'b0, tccc_pkg::CHAR_LF);
        tbl_item(1'b1, 21'h0);
        // zero-size grid: every print scrolls at the top row
        tbl_size(8'd0, 8'd0);
        tbl_item(1'b0, 21'h48);
        tbl_item(1'b0, tccc_pkg::CHAR_BS);
        tbl_item(1'b0, tccc_pkg::CHAR_TAB);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tbl[i])
        begin
            row = dir_tbl[i];
            if (row.is_cfg)
                set_size(row.cols_v, row.rows_v);
            else
            begin
                push_item(row.clr, row.code, row.n_typed == 0);
                if (row.n_typed > 0)
                    pending_cmds.push_back(row.exp_a);
                if (row.n_typed > 1)
                    pending_cmds.push_back(row.exp_b);
            end
        end

        // Random phases over several grid sizes and idle schemes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_size(ph_cols[p], ph_rows[p]);
            mode = idle_mode_t'(p % 4);
            case (mode)
                IDLE_NONE:     begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                IDLE_SENDER:   begin snd_idle_pct = 71; rcv_stall_pct = 0;  end
                IDLE_RECEIVER: begin snd_idle_pct = 0;  rcv_stall_pct = 71; end
                default:       begin snd_idle_pct = 24; rcv_stall_pct = 24; end
            endcase
            // long receiver hold-off so the input side backs up
            if (mode == IDLE_NONE)
                hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_item($urandom_range(99) < CLEAR_PCT, pick_code(), 1'b1);
        end

        s_tvalid <= 1'b0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
